// File: hdl/at_to_xt_scancode_translator_defines.svh
// Assertion macros for the translator's checker.
`ifndef AT_TO_XT_SCANCODE_TRANSLATOR_DEFINES_SVH
`define AT_TO_XT_SCANCODE_TRANSLATOR_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define ATXT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ATXT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/atxt_pkg.sv
// Shared constants, types and the set-2 to set-1 lookup for the scan code translator.
package atxt_pkg;

   localparam int ROM_SIZE    = 132;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [7:0] BYTE_BREAK    = 8'hF0;
   localparam logic [7:0] BYTE_EXT      = 8'hE0;
   localparam logic [7:0] BYTE_PAUSE    = 8'hE1;
   localparam logic [7:0] BYTE_ACK      = 8'hFA;
   localparam logic [7:0] BYTE_BAT_OK   = 8'hAA;
   localparam logic [7:0] BYTE_RESEND   = 8'hFE;
   localparam logic [7:0] BYTE_ECHO     = 8'hEE;
   localparam logic [7:0] SCAN_SCROLL   = 8'h7E;
   localparam logic [7:0] SCAN_NUM      = 8'h77;
   localparam logic [7:0] SCAN_CAPS     = 8'h58;
   localparam logic [7:0] CMD_SET_LEDS  = 8'hED;
   localparam logic [7:0] CMD_KB_RESET  = 8'hFF;
   localparam logic [7:0] BREAK_BIT     = 8'h80;

   localparam logic [2:0] LED_SCROLL = 3'b001;
   localparam logic [2:0] LED_NUM    = 3'b010;
   localparam logic [2:0] LED_CAPS   = 3'b100;

   typedef enum logic {
      REQ_SCAN     = 1'b0,
      REQ_KB_RESET = 1'b1
   } req_cmd_type;

   typedef struct packed {
      logic       to_keyboard;
      logic [7:0] data;
   } word_type;

   typedef struct packed {
      logic [1:0]         count;
      word_type [2:0]     words;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   localparam logic [7:0] XT_ROM [ROM_SIZE] = '{
      8'h00,8'h43,8'h00,8'h3F,8'h3D,8'h3B,8'h3C,8'h58,
      8'h00,8'h44,8'h42,8'h40,8'h3E,8'h0F,8'h29,8'h00,
      8'h00,8'h38,8'h2A,8'h00,8'h1D,8'h10,8'h02,8'h00,
      8'h00,8'h00,8'h2C,8'h1F,8'h1E,8'h11,8'h03,8'h00,
      8'h00,8'h2E,8'h2D,8'h20,8'h12,8'h05,8'h04,8'h00,
      8'h00,8'h39,8'h2F,8'h21,8'h14,8'h13,8'h06,8'h00,
      8'h00,8'h31,8'h30,8'h23,8'h22,8'h15,8'h07,8'h00,
      8'h00,8'h00,8'h32,8'h24,8'h16,8'h08,8'h09,8'h00,
      8'h00,8'h33,8'h25,8'h17,8'h18,8'h0B,8'h0A,8'h00,
      8'h00,8'h34,8'h35,8'h26,8'h27,8'h19,8'h0C,8'h00,
      8'h00,8'h00,8'h28,8'h00,8'h1A,8'h0D,8'h00,8'h00,
      8'h3A,8'h36,8'h1C,8'h1B,8'h00,8'h2B,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h0E,8'h00,
      8'h00,8'h4F,8'h00,8'h4B,8'h47,8'h00,8'h00,8'h00,
      8'h52,8'h53,8'h50,8'h4C,8'h4D,8'h48,8'h01,8'h45,
      8'h57,8'h4E,8'h51,8'h4A,8'h37,8'h49,8'h46,8'h00,
      8'h00,8'h00,8'h00,8'h41
   };

   function automatic logic [7:0] xt_lookup(input logic [7:0] code);
      if (code >= 8'(ROM_SIZE)) begin
         return 8'h00;
      end
      return XT_ROM[code];
   endfunction

endpackage

// File: hdl/atxt_req_if.sv
// Input channel: scan byte or keyboard reset event.
interface atxt_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] scan_byte;

   modport source (output valid, output cmd, output scan_byte, input ready);
   modport sink   (input valid, input cmd, input scan_byte, output ready);
endinterface

// File: hdl/atxt_rsp_if.sv
// Result channel: one byte for the PC or the keyboard.
interface atxt_rsp_if;
   logic       valid;
   logic       ready;
   logic       to_keyboard;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output to_keyboard, output out_byte, output last, input ready);
   modport sink   (input valid, input to_keyboard, input out_byte, input last, output ready);
endinterface

// File: hdl/atxt_front.sv
// Front end: accepts input words, tracks break/pause/LED state and builds output jobs.
module atxt_front (
   input  logic              clock,
   input  logic              reset,
   atxt_req_if.sink          req_word,
   input  logic              q_full,
   output logic              push,
   output atxt_pkg::job_type push_job
);

   logic       break_pending_ff, break_pending_in;
   logic       in_pause_ff, in_pause_in;
   logic [2:0] lock_leds_ff, lock_leds_in;
   logic       accept;
   logic [7:0] pc_byte;
   logic [2:0] led_mask;
   logic [2:0] leds_new;

   assign req_word.ready = !q_full;
   assign accept         = req_word.valid && req_word.ready;
   assign pc_byte        = atxt_pkg::xt_lookup(req_word.scan_byte) | atxt_pkg::BREAK_BIT;

   always_comb begin
      break_pending_in = break_pending_ff;
      in_pause_in      = in_pause_ff;
      lock_leds_in     = lock_leds_ff;
      push_job         = '0;
      led_mask         = 3'b000;
      leds_new         = lock_leds_ff;
      if (req_word.cmd == atxt_pkg::REQ_KB_RESET) begin
         push_job.count    = 2'd2;
         push_job.words[0] = '{to_keyboard: 1'b1, data: atxt_pkg::CMD_KB_RESET};
         push_job.words[1] = '{to_keyboard: 1'b0, data: atxt_pkg::BYTE_BAT_OK};
         lock_leds_in      = 3'b000;
      end else if (break_pending_ff) begin
         break_pending_in = 1'b0;
         priority if (req_word.scan_byte == atxt_pkg::SCAN_SCROLL) begin
            led_mask = atxt_pkg::LED_SCROLL;
         end else if (req_word.scan_byte == atxt_pkg::SCAN_NUM) begin
            if (in_pause_ff) begin
               in_pause_in = 1'b0;
            end else begin
               led_mask = atxt_pkg::LED_NUM;
            end
         end else if (req_word.scan_byte == atxt_pkg::SCAN_CAPS) begin
            led_mask = atxt_pkg::LED_CAPS;
         end else begin
            led_mask = 3'b000;
         end
         leds_new = lock_leds_ff ^ led_mask;
         if (led_mask != 3'b000) begin
            lock_leds_in      = leds_new;
            push_job.count    = 2'd3;
            push_job.words[0] = '{to_keyboard: 1'b1, data: atxt_pkg::CMD_SET_LEDS};
            push_job.words[1] = '{to_keyboard: 1'b1, data: {5'b00000, leds_new}};
            push_job.words[2] = '{to_keyboard: 1'b0, data: pc_byte};
         end else begin
            push_job.count    = 2'd1;
            push_job.words[0] = '{to_keyboard: 1'b0, data: pc_byte};
         end
      end else begin
         unique case (req_word.scan_byte)
            atxt_pkg::BYTE_ACK, atxt_pkg::BYTE_BAT_OK,
            atxt_pkg::BYTE_RESEND, atxt_pkg::BYTE_ECHO: begin
               push_job.count = 2'd0;
            end
            atxt_pkg::BYTE_BREAK: begin
               break_pending_in = 1'b1;
            end
            atxt_pkg::BYTE_PAUSE: begin
               in_pause_in       = 1'b1;
               push_job.count    = 2'd1;
               push_job.words[0] = '{to_keyboard: 1'b0, data: req_word.scan_byte};
            end
            atxt_pkg::BYTE_EXT: begin
               push_job.count    = 2'd1;
               push_job.words[0] = '{to_keyboard: 1'b0, data: req_word.scan_byte};
            end
            default: begin
               push_job.count    = 2'd1;
               push_job.words[0] = '{to_keyboard: 1'b0,
                                     data: atxt_pkg::xt_lookup(req_word.scan_byte)};
            end
         endcase
      end
   end

   assign push = accept && (push_job.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         break_pending_ff <= 1'b0;
         in_pause_ff      <= 1'b0;
         lock_leds_ff     <= 3'b000;
      end else if (accept) begin
         break_pending_ff <= break_pending_in;
         in_pause_ff      <= in_pause_in;
         lock_leds_ff     <= lock_leds_in;
      end
   end

endmodule

// File: hdl/atxt_queue.sv
// Job queue between front and back end.
module atxt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  atxt_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop,
   output atxt_pkg::head_type head
);

   atxt_pkg::job_type                  slot_ff [atxt_pkg::QUEUE_DEPTH];
   logic [atxt_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [atxt_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [atxt_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full       = (count_ff == atxt_pkg::QUEUE_CNT_W'(atxt_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: hdl/atxt_back.sv
// Back end: unrolls each job into output words through the output register.
module atxt_back (
   input  logic               clock,
   input  logic               reset,
   input  atxt_pkg::head_type head,
   output logic               pop,
   atxt_rsp_if.source         rsp_word
);

   logic                 valid_ff, valid_in;
   atxt_pkg::word_type   word_ff, word_in;
   logic                 last_ff, last_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 load;
   logic                 take;
   logic                 at_end;

   assign load   = !valid_ff || rsp_word.ready;
   assign take   = load && head.valid;
   assign at_end = (idx_ff == head.job.count - 2'd1);
   assign pop    = take && at_end;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (take) begin
         valid_in = 1'b1;
         word_in  = head.job.words[idx_ff];
         last_in  = at_end;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_word.valid       = valid_ff;
   assign rsp_word.to_keyboard = word_ff.to_keyboard;
   assign rsp_word.out_byte    = word_ff.data;
   assign rsp_word.last        = last_ff;

endmodule

// File: hdl/at_to_xt_scancode_translator.sv
// Top level of the AT set-2 to XT set-1 scan code translator.
// Takes one input word per cycle while the four-job queue between the front and back end
// has room; the front end classifies the byte and updates the break, pause and LED state in
// the same cycle. The back end sends one result word per cycle from its output register while
// the result channel is ready, so an input that causes 1 to 3 results holds the back end until
// all of them are sent, and an input that causes none never reaches it. The first result word
// of an input passes through a queue slot and then the output register.
// No clearing pass after reset.
module at_to_xt_scancode_translator (
   input  logic        clock,
   input  logic        reset,
   atxt_req_if.sink    req_word,
   atxt_rsp_if.source  rsp_word
);

   logic               push;
   atxt_pkg::job_type  push_job;
   logic               q_full;
   logic               pop;
   atxt_pkg::head_type head;

   atxt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .q_full   (q_full),
      .push     (push),
      .push_job (push_job)
   );

   atxt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .head     (head)
   );

   atxt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule

// File: hdl/atxt_checker.sv
// Port-level checker for the scan code translator, bound to the top level.
`include "at_to_xt_scancode_translator_defines.svh"

module atxt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_to_keyboard,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   logic stalled;
   logic kb_word;
   logic led_cmd_taken;
   logic led_byte_shown;

   assign stalled        = rsp_valid && !rsp_ready;
   assign kb_word        = rsp_valid && rsp_to_keyboard;
   assign led_cmd_taken  = kb_word && rsp_ready && (rsp_out_byte == atxt_pkg::CMD_SET_LEDS);
   assign led_byte_shown = kb_word && (rsp_out_byte[7:3] == 5'b00000);

   `ATXT_ASSERT(a_rsp_valid_holds, clock, reset, stalled |=> rsp_valid, "rsp valid dropped")

   `ATXT_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp valid after reset")

   `ATXT_ASSERT(a_kb_word_not_last, clock, reset, kb_word |-> !rsp_last, "keyboard word last")

   `ATXT_ASSERT(a_led_cmd_then_leds, clock, reset, led_cmd_taken |=> led_byte_shown, "no LED byte")

endmodule

bind at_to_xt_scancode_translator atxt_checker u_atxt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_word.valid),
   .rsp_ready       (rsp_word.ready),
   .rsp_to_keyboard (rsp_word.to_keyboard),
   .rsp_out_byte    (rsp_word.out_byte),
   .rsp_last        (rsp_word.last)
);
